FILE: rtl/core/mmewb_pkg.sv
// ----------------------------------------------------------------------------
// mmewb_pkg
// Shared widths, defaults and interface types for the equal-width binning
// block and its serial divider.
// ----------------------------------------------------------------------------
package mmewb_pkg;

    localparam int QUAL_W         = 32;                // Q16.16 value width
    localparam int NSEC_W         = 9;                 // bin count register width
    localparam int BIN_W          = 8;                 // bin index width
    localparam int PROD_W         = QUAL_W + NSEC_W;   // sections * (v - min)
    localparam int MAX_VALUES_DEF = 64;
    localparam int NSEC_MAX       = 256;

    localparam logic [NSEC_W-1:0] NSEC_RESET = NSEC_W'(10);

    // Divider request: start pulse plus operands
    typedef struct packed {
        logic              start;
        logic [QUAL_W-1:0] diff;      // v - min
        logic [QUAL_W-1:0] span;      // max - min
        logic [NSEC_W-1:0] sections;  // effective bin count, 1..256
    } div_req_t;

    // Divider response: result held until taken
    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } div_rsp_t;

    // Map the raw register to 1..256
    function automatic logic [NSEC_W-1:0] sections_eff(input logic [NSEC_W-1:0] ns);
        logic [NSEC_W-1:0] r;
        if (ns == '0) begin
            r = NSEC_W'(1);
        end else if (ns > NSEC_W'(NSEC_MAX)) begin
            r = NSEC_W'(NSEC_MAX);
        end else begin
            r = ns;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/minmax_equal_width_binning.sv
// ----------------------------------------------------------------------------
// minmax_equal_width_binning
// Stores a set of Q16.16 values with their running min and max, then emits
// one equal-width bin index per stored value in arrival order.
// ----------------------------------------------------------------------------
// Values are taken one per cycle while the set loads. The transaction marked
// last ends the set and starts emission; s_ready stays low until the final
// bin index is in the output register. Each bin index goes through a
// memory read, operand setup, a multiply step and a 9-step restoring divider
// that yields one quotient bit per cycle; one index is computed at a time.
// Values beyond MAX_VALUES are dropped and every result of that set carries
// m_overflowed. The user must write num_sections via cfg_wr_en/cfg_wr_data
// only between sets (unchecked by the block); 0 acts as 1, above 256 as 256.
// ----------------------------------------------------------------------------
module minmax_equal_width_binning
    import mmewb_pkg::*;
#(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [QUAL_W-1:0] s_quality,
    input  logic              s_last_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BIN_W-1:0]  m_bin_index,
    output logic              m_overflowed,
    output logic              m_last_result,
    input  logic              cfg_wr_en,
    input  logic [NSEC_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_START = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [QUAL_W-1:0]  min_reg, min_next;
    logic [QUAL_W-1:0]  max_reg, max_next;
    logic               drop_reg, drop_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [NSEC_W-1:0]  ns_reg;
    logic [QUAL_W-1:0]  rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]   out_bin_reg, out_bin_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    logic [QUAL_W-1:0]  mem [MAX_VALUES];

    logic               accept;
    logic               has_room;
    logic               final_idx;
    logic               out_free;
    logic               load_out;
    div_req_t           req;
    div_rsp_t           rsp;

    assign s_ready   = (state_reg == ST_LOAD);
    assign accept    = s_valid && s_ready;
    assign has_room  = count_reg < CW'(MAX_VALUES);
    assign final_idx = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_WAIT) && rsp.done && out_free;

    assign req.start    = (state_reg == ST_START);
    assign req.diff     = rd_data_reg - min_reg;
    assign req.span     = max_reg - min_reg;
    assign req.sections = sections_eff(ns_reg);

    mmewb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .take    (load_out),
        .rsp     (rsp)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        drop_next      = drop_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_bin_next   = out_bin_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (has_room) begin
                        count_next = count_reg + CW'(1);
                        if (s_quality < min_reg) begin
                            min_next = s_quality;
                        end
                        if (s_quality > max_reg) begin
                            max_next = s_quality;
                        end
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last_value) begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_bin_next   = rsp.bin;
                    out_ovf_next   = drop_reg;
                    out_last_next  = final_idx;
                    if (final_idx) begin
                        // set done: clear for the next one
                        count_next = '0;
                        min_next   = '1;
                        max_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            ns_reg        <= NSEC_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            drop_reg      <= drop_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                ns_reg <= cfg_wr_data;
            end
        end
        out_bin_reg  <= out_bin_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // Value store: written while loading, read once per emitted result
    always_ff @(posedge aclk) begin
        if (accept && has_room) begin
            mem[count_reg[AW-1:0]] <= s_quality;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_bin_index   = out_bin_reg;
    assign m_overflowed  = out_ovf_reg;
    assign m_last_result = out_last_reg;

endmodule

FILE: rtl/core/mmewb_div.sv
// ----------------------------------------------------------------------------
// mmewb_div
// Bin index unit: a multiply step, then a restoring divider that produces
// one quotient bit per cycle, then clamp to sections - 1 (bin 0 if span is 0).
// ----------------------------------------------------------------------------
module mmewb_div
    import mmewb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    input  logic     take,
    output div_rsp_t rsp
);

    localparam int STEP_CW = $clog2(NSEC_W);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_DIV  = 4'b0100,
        D_DONE = 4'b1000
    } dstate_t;

    dstate_t              state_reg, state_next;
    logic [QUAL_W-1:0]    diff_reg, diff_next;
    logic [QUAL_W-1:0]    span_reg, span_next;
    logic [NSEC_W-1:0]    sec_reg, sec_next;
    logic                 zspan_reg, zspan_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    dsor_reg, dsor_next;
    logic [NSEC_W-1:0]    quo_reg, quo_next;
    logic [STEP_CW-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]    prod;
    logic                 fits;

    assign prod = PROD_W'(sec_reg) * PROD_W'(diff_reg);
    assign fits = rem_reg >= dsor_reg;

    always_comb begin
        state_next = state_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        sec_next   = sec_reg;
        zspan_next = zspan_reg;
        rem_next   = rem_reg;
        dsor_next  = dsor_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    diff_next  = req.diff;
                    span_next  = req.span;
                    sec_next   = req.sections;
                    state_next = D_MUL;
                end
            end
            D_MUL: begin
                rem_next   = prod;
                // align divisor with the top quotient bit
                dsor_next  = PROD_W'(span_reg) << (NSEC_W - 1);
                zspan_next = (span_reg == '0);
                quo_next   = '0;
                step_next  = STEP_CW'(NSEC_W - 1);
                state_next = D_DIV;
            end
            D_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsor_reg;
                end
                quo_next  = {quo_reg[NSEC_W-2:0], fits};
                dsor_next = dsor_reg >> 1;
                if (step_reg == '0) begin
                    state_next = D_DONE;
                end else begin
                    step_next = step_reg - STEP_CW'(1);
                end
            end
            D_DONE: begin
                if (take) begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        diff_reg  <= diff_next;
        span_reg  <= span_next;
        sec_reg   <= sec_next;
        zspan_reg <= zspan_next;
        rem_reg   <= rem_next;
        dsor_reg  <= dsor_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
    end

    // Flat range gives bin 0; the maximum itself lands on sections, clamp it
    always_comb begin
        rsp.done = (state_reg == D_DONE);
        if (zspan_reg) begin
            rsp.bin = '0;
        end else if (quo_reg >= sec_reg) begin
            rsp.bin = BIN_W'(sec_reg - NSEC_W'(1));
        end else begin
            rsp.bin = BIN_W'(quo_reg);
        end
    end

endmodule

FILE: rtl/core/mmewb_checker.sv
// ----------------------------------------------------------------------------
// mmewb_checker
// Port-level checks on load/emit sequencing and the result channel.
// ----------------------------------------------------------------------------
module mmewb_checker
    import mmewb_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_last_value,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BIN_W-1:0]  m_bin_index,
    input logic              m_overflowed,
    input logic              m_last_result
);

    // A last transaction ends loading
    a_last_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_value |=> !s_ready)
        else $error("input still ready after last transaction");

    // Loading continues until the last transaction
    a_load_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_value |=> s_ready)
        else $error("input stalled during loading");

    // No new set is taken while a set is still being emitted
    a_no_load_midset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_result |-> !s_ready)
        else $error("input ready while emission is in progress");

    // Held result does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index)
            && $stable(m_overflowed) && $stable(m_last_result))
        else $error("result changed while stalled");

endmodule

bind minmax_equal_width_binning mmewb_checker u_mmewb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_value  (s_last_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_bin_index   (m_bin_index),
    .m_overflowed  (m_overflowed),
    .m_last_result (m_last_result)
);
